FILE: src/i2r_pkg.sv
`timescale 1ns / 1ps
package i2r_pkg;

  // ASCII codes of the characters the encoder can produce
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_V     = 8'h56;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Decimal place codes
  localparam logic [1:0] PLACE_UNITS    = 2'd0;
  localparam logic [1:0] PLACE_TENS     = 2'd1;
  localparam logic [1:0] PLACE_HUNDREDS = 2'd2;

  // Reciprocal constants for the constant divisions.
  // m / 1000 = (m * 33555) >> 25 for m < 32768
  // r / 100  = (r * 41) >> 12    for r < 1000
  // r / 10   = (r * 205) >> 11   for r < 100
  localparam logic [15:0] RECIP_THOUSAND = 16'd33555;
  localparam logic [5:0]  RECIP_HUNDRED  = 6'd41;
  localparam logic [7:0]  RECIP_TEN      = 8'd205;
  localparam logic [9:0]  THOUSAND       = 10'd1000;
  localparam logic [6:0]  HUNDRED        = 7'd100;
  localparam logic [3:0]  TEN            = 4'd10;
  localparam logic [14:0] MAG_MAX        = 15'h7FFF;

  // Decomposed value handed from the front to the back
  typedef struct packed {
    logic       neg;
    logic [5:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } item_t;

  // One character waiting in the output queue
  typedef struct packed {
    logic       last;
    logic [7:0] char_code;
  } out_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_THOU,
    F_REM,
    F_HUND,
    F_SUBH,
    F_TENS,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

  // Number of letters in the pattern of a nonzero digit
  function automatic logic [2:0] pattern_len(input logic [3:0] d);
    logic [2:0] len;
    if (d == 4'd9 || d == 4'd4) begin
      len = 3'd2;
    end else if (d >= 4'd5) begin
      len = 3'(d - 4'd4);
    end else begin
      len = d[2:0];
    end
    return len;
  endfunction

  // Letter at position pos of the pattern of digit d at the given place
  function automatic logic [7:0] pattern_letter(input logic [3:0] d,
                                                input logic [1:0] place,
                                                input logic [2:0] pos);
    logic [7:0] one;
    logic [7:0] five;
    logic [7:0] ten;
    logic [7:0] c;
    unique case (place)
      PLACE_HUNDREDS: begin
        one = CHAR_C; five = CHAR_D; ten = CHAR_M;
      end
      PLACE_TENS: begin
        one = CHAR_X; five = CHAR_L; ten = CHAR_C;
      end
      default: begin
        one = CHAR_I; five = CHAR_V; ten = CHAR_X;
      end
    endcase
    if (d == 4'd9) begin
      c = (pos == 3'd0) ? one : ten;
    end else if (d == 4'd4) begin
      c = (pos == 3'd0) ? one : five;
    end else if (d >= 4'd5) begin
      c = (pos == 3'd0) ? five : one;
    end else begin
      c = one;
    end
    return c;
  endfunction

endpackage

FILE: src/i2r_fifo.sv
`timescale 1ns / 1ps
module i2r_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  // The user must keep DEPTH a power of two, at least 2, so the pointers wrap on their own; nothing here checks it
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW-1:0]    rd_ptr_nxt;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: src/i2r_front.sv
`timescale 1ns / 1ps
module i2r_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_value,
  output logic               q_wr,
  output i2r_pkg::item_t     q_item,
  input  logic               q_full
);

  i2r_pkg::front_state_t state_r;
  i2r_pkg::front_state_t state_nxt;

  logic        neg_r,  neg_nxt;
  logic [14:0] mag_r,  mag_nxt;
  logic [5:0]  thou_r, thou_nxt;
  logic [9:0]  rem_r,  rem_nxt;
  logic [3:0]  hund_r, hund_nxt;
  logic [6:0]  r2_r,   r2_nxt;
  logic [3:0]  tens_r, tens_nxt;

  logic [15:0] raw;
  logic [15:0] negated;
  logic        accept;
  logic [30:0] thou_prod;
  logic [15:0] thou_back;
  logic [15:0] rem_full;
  logic [15:0] hund_prod;
  logic [9:0]  hund_back;
  logic [9:0]  r2_full;
  logic [14:0] tens_prod;
  logic [6:0]  tens_back;
  logic [6:0]  units_full;

  // Sign and magnitude; the most negative pattern saturates
  assign raw     = in_value;
  assign negated = ~raw + 16'd1;

  // One multiplication per state, each result registered but the units digit, formed combinationally
  assign thou_prod  = 31'(mag_r) * 31'(i2r_pkg::RECIP_THOUSAND);
  assign thou_back  = 16'(thou_r) * 16'(i2r_pkg::THOUSAND);
  assign rem_full   = 16'(mag_r) - thou_back;
  assign hund_prod  = 16'(rem_r) * 16'(i2r_pkg::RECIP_HUNDRED);
  assign hund_back  = 10'(hund_r) * 10'(i2r_pkg::HUNDRED);
  assign r2_full    = rem_r - hund_back;
  assign tens_prod  = 15'(r2_r) * 15'(i2r_pkg::RECIP_TEN);
  assign tens_back  = 7'(tens_r) * 7'(i2r_pkg::TEN);
  assign units_full = r2_r - tens_back;

  assign q_item.neg   = neg_r;
  assign q_item.thou  = thou_r;
  assign q_item.hund  = hund_r;
  assign q_item.tens  = tens_r;
  assign q_item.units = units_full[3:0];

  // Next state and outputs
  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    thou_nxt  = thou_r;
    rem_nxt   = rem_r;
    hund_nxt  = hund_r;
    r2_nxt    = r2_r;
    tens_nxt  = tens_r;
    q_wr      = 1'b0;
    full      = 1'b1;
    accept    = 1'b0;
    unique case (state_r)
      i2r_pkg::F_IDLE: begin
        full = 1'b0;
      end
      i2r_pkg::F_THOU: begin
        thou_nxt  = thou_prod[30:25];
        state_nxt = i2r_pkg::F_REM;
      end
      i2r_pkg::F_REM: begin
        rem_nxt   = rem_full[9:0];
        state_nxt = i2r_pkg::F_HUND;
      end
      i2r_pkg::F_HUND: begin
        hund_nxt  = hund_prod[15:12];
        state_nxt = i2r_pkg::F_SUBH;
      end
      i2r_pkg::F_SUBH: begin
        r2_nxt    = r2_full[6:0];
        state_nxt = i2r_pkg::F_TENS;
      end
      i2r_pkg::F_TENS: begin
        tens_nxt  = tens_prod[14:11];
        state_nxt = i2r_pkg::F_PUSH;
      end
      i2r_pkg::F_PUSH: begin
        if (!q_full) begin
          q_wr      = 1'b1;
          full      = 1'b0;
          state_nxt = i2r_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = i2r_pkg::F_IDLE;
      end
    endcase
    // A new value may enter in the cycle the previous one leaves
    accept = push && !full;
    if (accept) begin
      neg_nxt   = raw[15];
      mag_nxt   = raw[15] ? (negated[15] ? i2r_pkg::MAG_MAX : negated[14:0]) : raw[14:0];
      state_nxt = i2r_pkg::F_THOU;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2r_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    thou_r <= thou_nxt;
    rem_r  <= rem_nxt;
    hund_r <= hund_nxt;
    r2_r   <= r2_nxt;
    tens_r <= tens_nxt;
  end

endmodule

FILE: src/i2r_back.sv
`timescale 1ns / 1ps
module i2r_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  i2r_pkg::item_t q_item,
  output logic           q_rd,
  input  logic           o_full,
  output logic           o_wr,
  output i2r_pkg::out_t  o_data
);

  i2r_pkg::back_state_t state_r;
  i2r_pkg::back_state_t state_nxt;

  logic       sign_r,  sign_nxt;
  logic       zero_r,  zero_nxt;
  logic [5:0] thou_r,  thou_nxt;
  logic [3:0] hund_r,  hund_nxt;
  logic [3:0] tens_r,  tens_nxt;
  logic [3:0] units_r, units_nxt;
  logic [1:0] place_r, place_nxt;
  logic [2:0] pos_r,   pos_nxt;

  logic       any_dig;
  logic       lower_nz;
  logic [1:0] lower_place;
  logic [3:0] cur_d;
  logic [2:0] cur_len;
  logic       end_of_pat;
  logic       emit;
  logic       load;
  logic       in_any;

  // Current digit and what follows it
  always_comb begin
    unique case (place_r)
      i2r_pkg::PLACE_HUNDREDS: begin
        cur_d       = hund_r;
        lower_nz    = (tens_r != 4'd0) || (units_r != 4'd0);
        lower_place = (tens_r != 4'd0) ? i2r_pkg::PLACE_TENS : i2r_pkg::PLACE_UNITS;
      end
      i2r_pkg::PLACE_TENS: begin
        cur_d       = tens_r;
        lower_nz    = (units_r != 4'd0);
        lower_place = i2r_pkg::PLACE_UNITS;
      end
      default: begin
        cur_d       = units_r;
        lower_nz    = 1'b0;
        lower_place = i2r_pkg::PLACE_UNITS;
      end
    endcase
  end

  assign any_dig    = (hund_r != 4'd0) || (tens_r != 4'd0) || (units_r != 4'd0);
  assign cur_len    = i2r_pkg::pattern_len(cur_d);
  assign end_of_pat = (pos_r == cur_len - 3'd1);
  assign in_any     = (q_item.hund != 4'd0) || (q_item.tens != 4'd0) ||
                      (q_item.units != 4'd0);

  // Character select: sign, zero, thousands, then the digit patterns
  always_comb begin
    priority if (sign_r) begin
      o_data.char_code = i2r_pkg::CHAR_MINUS;
      o_data.last      = (thou_r == 6'd0) && !any_dig;
    end else if (zero_r) begin
      o_data.char_code = i2r_pkg::CHAR_N;
      o_data.last      = 1'b1;
    end else if (thou_r != 6'd0) begin
      o_data.char_code = i2r_pkg::CHAR_M;
      o_data.last      = (thou_r == 6'd1) && !any_dig;
    end else begin
      o_data.char_code = i2r_pkg::pattern_letter(cur_d, place_r, pos_r);
      o_data.last      = end_of_pat && !lower_nz;
    end
  end

  // Sequencer: one character per cycle while the output queue has room, next value loaded on the last one
  always_comb begin
    state_nxt = state_r;
    sign_nxt  = sign_r;
    zero_nxt  = zero_r;
    thou_nxt  = thou_r;
    hund_nxt  = hund_r;
    tens_nxt  = tens_r;
    units_nxt = units_r;
    place_nxt = place_r;
    pos_nxt   = pos_r;
    emit      = 1'b0;
    unique case (state_r)
      i2r_pkg::B_IDLE: begin
        emit = 1'b0;
      end
      i2r_pkg::B_EMIT: begin
        emit = !o_full;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    o_wr = emit;

    if (emit) begin
      priority if (sign_r) begin
        sign_nxt = 1'b0;
      end else if (zero_r) begin
        zero_nxt = 1'b0;
      end else if (thou_r != 6'd0) begin
        thou_nxt = thou_r - 6'd1;
      end else if (end_of_pat) begin
        pos_nxt   = 3'd0;
        place_nxt = lower_place;
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
      if (o_data.last) begin
        state_nxt = i2r_pkg::B_IDLE;
      end
    end

    load = !q_empty && ((state_r == i2r_pkg::B_IDLE) || (emit && o_data.last));
    q_rd = load;
    if (load) begin
      state_nxt = i2r_pkg::B_EMIT;
      sign_nxt  = q_item.neg;
      zero_nxt  = !q_item.neg && (q_item.thou == 6'd0) && !in_any;
      thou_nxt  = q_item.thou;
      hund_nxt  = q_item.hund;
      tens_nxt  = q_item.tens;
      units_nxt = q_item.units;
      pos_nxt   = 3'd0;
      if (q_item.hund != 4'd0) begin
        place_nxt = i2r_pkg::PLACE_HUNDREDS;
      end else if (q_item.tens != 4'd0) begin
        place_nxt = i2r_pkg::PLACE_TENS;
      end else begin
        place_nxt = i2r_pkg::PLACE_UNITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2r_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sign_r  <= sign_nxt;
    zero_r  <= zero_nxt;
    thou_r  <= thou_nxt;
    hund_r  <= hund_nxt;
    tens_r  <= tens_nxt;
    units_r <= units_nxt;
    place_r <= place_nxt;
    pos_r   <= pos_nxt;
  end

endmodule

FILE: src/integer_to_roman_encoder_unit.sv
`timescale 1ns / 1ps
// Channel  | Ports                          | Transfer when
// ---------+--------------------------------+---------------------
// input    | push, full, in_value           | push && !full
// result   | pop, empty, out_char_code,     | pop && !empty
//          | out_last                       |
//
// The front splits a value into thousands, hundreds, tens and units with
// reciprocal multiplies, one per cycle; it takes a new value only as the
// last one is pushed into the item queue. The back sends one character per
// cycle while the output queue has room, 1 to 44 per value.
// Synchronous reset clears the sequencers, queue pointers and fill counts only.
// With pop held low the output queue fills and the back holds its place;
// the front keeps working until the item queue is full.
module integer_to_roman_encoder_unit #(
  parameter int QUEUE_DEPTH = 2,
  parameter int OUT_DEPTH   = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_value,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_char_code,
  output logic               out_last
);

  localparam int ItemW = $bits(i2r_pkg::item_t);
  localparam int OutW  = $bits(i2r_pkg::out_t);

  i2r_pkg::item_t f_item;
  i2r_pkg::item_t b_item;
  i2r_pkg::out_t  b_out;
  i2r_pkg::out_t  o_head;
  logic           q_wr;
  logic           q_full;
  logic           q_rd;
  logic           q_empty;
  logic           o_wr;
  logic           o_full;

  // Front: accept and decompose
  i2r_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_value (in_value),
    .q_wr     (q_wr),
    .q_item   (f_item),
    .q_full   (q_full)
  );

  // Queue of decomposed values between front and back
  i2r_fifo #(
    .WIDTH (ItemW),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (f_item),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (b_item),
    .empty   (q_empty)
  );

  // Back: character sequencer
  i2r_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (b_item),
    .q_rd    (q_rd),
    .o_full  (o_full),
    .o_wr    (o_wr),
    .o_data  (b_out)
  );

  // Output queue decouples the sequencer from the consumer
  i2r_fifo #(
    .WIDTH (OutW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (o_wr),
    .wr_data (b_out),
    .full    (o_full),
    .rd_en   (pop),
    .rd_data (o_head),
    .empty   (empty)
  );

  assign out_char_code = o_head.char_code;
  assign out_last      = o_head.last;

endmodule

FILE: src/i2r_checker.sv
`timescale 1ns / 1ps
module i2r_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               push,
  input logic               full,
  input logic signed [15:0] in_value,
  input logic               empty,
  input logic               pop,
  input logic [7:0]         out_char_code,
  input logic               out_last
);

  // Both sides come out of reset idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queues not idle after reset");

  // Only numeral letters, N and minus ever appear
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_char_code == i2r_pkg::CHAR_I) || (out_char_code == i2r_pkg::CHAR_V) ||
               (out_char_code == i2r_pkg::CHAR_X) || (out_char_code == i2r_pkg::CHAR_L) ||
               (out_char_code == i2r_pkg::CHAR_C) || (out_char_code == i2r_pkg::CHAR_D) ||
               (out_char_code == i2r_pkg::CHAR_M) || (out_char_code == i2r_pkg::CHAR_N) ||
               (out_char_code == i2r_pkg::CHAR_MINUS))
    else $error("unexpected character code");

  // N ends its result; a minus sign is never the last character
  a_n_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_char_code == i2r_pkg::CHAR_N) |-> out_last)
    else $error("N not flagged last");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_char_code == i2r_pkg::CHAR_MINUS) |-> !out_last)
    else $error("minus flagged last");

  // A waiting result holds until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_char_code) && $stable(out_last))
    else $error("waiting result changed");

endmodule

bind integer_to_roman_encoder_unit i2r_checker u_i2r_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .in_value      (in_value),
  .empty         (empty),
  .pop           (pop),
  .out_char_code (out_char_code),
  .out_last      (out_last)
);
